### hw/rtl/sai_pkg.sv
// Package for the set-associative id index: sizes, field types, action codes
// and the command and status structs shared by the controller and the datapath.
// No dependencies.
package sai_pkg;

   localparam int NUM_SETS = 1024;
   localparam int WAYS     = 8;

   localparam int ID_W    = 31;
   localparam int LOC_W   = 15;
   localparam int RID_W   = 32;
   localparam int OCC_W   = 14;
   localparam int SETS_W  = 11;
   localparam int SET_W   = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
   localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
   // The first remainder estimate stays below twice the set count.
   localparam int MOD_W   = $clog2(2 * NUM_SETS);
   localparam int RECIP_W = 32;
   localparam int PROD_W  = ID_W + RECIP_W;
   localparam int DIV_CNT_W = $clog2(RECIP_W + 1);

   localparam logic ACT_LOOKUP = 1'b0;
   localparam logic ACT_ADD    = 1'b1;

   typedef struct packed {
      logic            action;
      logic [ID_W-1:0] id;
      logic            batch_end;
   } req_type;

   typedef struct packed {
      logic signed [LOC_W-1:0] location;
      logic                    found;
      logic signed [RID_W-1:0] return_id;
      logic [OCC_W-1:0]        occupied;
      logic                    last_out;
   } rsp_type;

   typedef struct packed {
      logic            valid;
      logic [ID_W-1:0] id;
   } entry_type;

   typedef entry_type [WAYS-1:0] row_type;

   localparam int ROW_W = $bits(row_type);

   typedef struct packed {
      logic restart;
      logic clear_step;
      logic load;
      logic mul;
      logic qd;
      logic rd;
      logic cmp;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic recip_done;
   } status_type;

endpackage

### hw/rtl/sai_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module sai_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### hw/rtl/sai_ctrl.sv
// Controller of the set-associative id index: sequences the clearing pass
// and the steps of one item. Depends on sai_pkg.
module sai_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 csr_fire,
   input  sai_pkg::status_type  status,
   output sai_pkg::cmd_type     cmd,
   output logic                 busy
);
   import sai_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL,
      ST_QD,
      ST_RD,
      ST_CMP
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last && status.recip_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL:  state_in = ST_QD;
         ST_QD:   state_in = ST_RD;
         ST_RD:   state_in = ST_CMP;
         ST_CMP:  state_in = ST_IDLE;
         default: state_in = ST_CLEAR;
      endcase
      // A register write changes the slot mapping, so the store is swept again.
      if (csr_fire) begin
         state_in = ST_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         busy_ff  <= 1'b1;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != ST_IDLE);
      end
   end

   always_comb begin
      cmd            = '0;
      cmd.restart    = csr_fire;
      cmd.clear_step = (state_ff == ST_CLEAR);
      cmd.load       = (state_ff == ST_IDLE) && start;
      cmd.mul        = (state_ff == ST_MUL);
      cmd.qd         = (state_ff == ST_QD);
      cmd.rd         = (state_ff == ST_RD);
      cmd.cmp        = (state_ff == ST_CMP);
   end

   assign busy = busy_ff;

endmodule

### hw/rtl/sai_dp.sv
// Datapath of the set-associative id index: set register, reciprocal divider,
// modulo pipeline, tag row memory, way compare and occupancy count.
// Depends on sai_pkg and sai_ram.
module sai_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  sai_pkg::cmd_type            cmd,
   output sai_pkg::status_type         status,
   input  sai_pkg::req_type            req_data,
   input  logic [sai_pkg::SETS_W-1:0]  csr_wdata,
   output logic                        rsp_valid,
   output sai_pkg::rsp_type            rsp_data
);
   import sai_pkg::*;

   logic [SETS_W-1:0]    sets_ff;
   logic [SETS_W-1:0]    dsets;
   logic [SETS_W-1:0]    div_rem_ff, div_rem_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic [RECIP_W-1:0]   recip_ff;
   logic [SETS_W:0]      div_trial;
   logic                 div_ge;
   logic                 div_run;
   logic [SET_W-1:0]     clr_addr_ff;
   logic [OCC_W-1:0]     occ_ff, occ_in;
   req_type              req_ff;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [MOD_W+SETS_W-1:0] qd_full;
   logic [MOD_W-1:0]     rem0_ff, rem0_in, rem_sub, rem_fin;
   logic [SET_W-1:0]     set_ff, set_in;
   logic [ROW_W-1:0]     ram_rdata, ram_wdata;
   logic [SET_W-1:0]     ram_waddr;
   logic                 ram_we;
   row_type              row, new_row;
   logic                 hit, empty;
   logic [WAY_W-1:0]     hit_way, empty_way;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff, rsp_in;

   // Zero sets act as one set; more than the store holds is clamped.
   always_comb begin
      dsets = sets_ff;
      if (sets_ff == '0) begin
         dsets = SETS_W'(1);
      end else if (sets_ff > SETS_W'(NUM_SETS)) begin
         dsets = SETS_W'(NUM_SETS);
      end
   end

   // Restoring divider for floor((2^32 - 1) / sets), one quotient bit a cycle.
   assign div_run    = (div_cnt_ff != DIV_CNT_W'(RECIP_W));
   assign div_trial  = {div_rem_ff, 1'b1};
   assign div_ge     = (div_trial >= {1'b0, dsets});
   assign div_rem_in = div_ge ? SETS_W'(div_trial - {1'b0, dsets}) : SETS_W'(div_trial);

   always_ff @(posedge clock) begin
      if (reset) begin
         sets_ff     <= SETS_W'(NUM_SETS);
         div_cnt_ff  <= '0;
         div_rem_ff  <= '0;
         clr_addr_ff <= '0;
         occ_ff      <= '0;
      end else if (cmd.restart) begin
         sets_ff     <= csr_wdata;
         div_cnt_ff  <= '0;
         div_rem_ff  <= '0;
         clr_addr_ff <= '0;
         occ_ff      <= '0;
      end else begin
         if (div_run) begin
            div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
            div_rem_ff <= div_rem_in;
         end
         if (cmd.clear_step) begin
            clr_addr_ff <= clr_addr_ff + SET_W'(1);
         end
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (div_run) begin
         recip_ff <= {recip_ff[RECIP_W-2:0], div_ge};
      end
   end

   assign status.clear_last = (clr_addr_ff == SET_W'(NUM_SETS - 1));
   assign status.recip_done = !div_run;

   // The quotient estimate is low by at most one, so the remainder estimate
   // is below twice the set count and needs only its low bits.
   assign prod_in = req_ff.id * recip_ff;
   assign qd_full = prod_ff[RECIP_W +: MOD_W] * dsets;
   assign rem0_in = req_ff.id[MOD_W-1:0] - qd_full[MOD_W-1:0];
   assign rem_sub = rem0_ff - MOD_W'(dsets);
   assign rem_fin = (rem0_ff >= MOD_W'(dsets)) ? rem_sub : rem0_ff;
   assign set_in  = rem_fin[SET_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.mul) begin
         prod_ff <= prod_in;
      end
      if (cmd.qd) begin
         rem0_ff <= rem0_in;
      end
      if (cmd.rd) begin
         set_ff <= set_in;
      end
   end

   sai_ram #(
      .WIDTH (ROW_W),
      .DEPTH (NUM_SETS)
   ) u_tag_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (set_in),
      .rdata (ram_rdata)
   );

   assign row = row_type'(ram_rdata);

   always_comb begin
      hit       = 1'b0;
      hit_way   = '0;
      empty     = 1'b0;
      empty_way = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (!hit && row[w].valid && (row[w].id == req_ff.id)) begin
            hit     = 1'b1;
            hit_way = WAY_W'(w);
         end
         if (!empty && !row[w].valid) begin
            empty     = 1'b1;
            empty_way = WAY_W'(w);
         end
      end
   end

   always_comb begin
      new_row                 = row;
      new_row[empty_way].valid = 1'b1;
      new_row[empty_way].id    = req_ff.id;
   end

   assign ram_we    = cmd.clear_step || (cmd.cmp && (req_ff.action == ACT_ADD) && empty);
   assign ram_waddr = cmd.clear_step ? clr_addr_ff : set_ff;
   assign ram_wdata = cmd.clear_step ? '0 : ROW_W'(new_row);

   always_comb begin
      occ_in = occ_ff;
      if (cmd.cmp && (req_ff.action == ACT_ADD) && empty) begin
         occ_in = occ_ff + OCC_W'(1);
      end
   end

   always_comb begin
      rsp_in          = '0;
      rsp_in.occupied = occ_in;
      rsp_in.last_out = req_ff.batch_end;
      if (req_ff.action == ACT_LOOKUP) begin
         rsp_in.found = hit;
         if (hit) begin
            rsp_in.location  = LOC_W'(set_ff) * LOC_W'(WAYS) + LOC_W'(hit_way);
            rsp_in.return_id = {1'b0, req_ff.id};
         end else begin
            rsp_in.location  = LOC_W'(dsets) * LOC_W'(WAYS);
            rsp_in.return_id = '1;
         end
      end else begin
         rsp_in.found     = empty;
         rsp_in.return_id = {1'b0, req_ff.id};
         if (empty) begin
            rsp_in.location = LOC_W'(set_ff) * LOC_W'(WAYS) + LOC_W'(empty_way);
         end else begin
            rsp_in.location = '1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.cmp;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cmp) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### hw/rtl/set_assoc_id_index_core.sv
// Top level of the 8-way set-associative id index.
// Depends on sai_pkg, sai_ctrl and sai_dp.
//
//   channel   ports                            direction  beat taken when
//   request   start, busy, req_data            in         start && !busy
//   response  rsp_valid, rsp_data              out        rsp_valid (one cycle)
//   csr       csr_valid, csr_ready, csr_wdata  in         csr_valid && csr_ready
//
// An accepted item goes through four steps: a reciprocal multiply, a
// remainder multiply, a correction with the row read and a compare with
// write-back, whose response is registered. busy stays high through them,
// so the next beat can be taken at the edge that ends the strobe.
// After reset and after every csr write all 1024 rows of the tag memory are
// swept, one row a cycle, while busy is high; the reciprocal of the set
// count is formed during the sweep. The response cannot be stalled.
module set_assoc_id_index_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  sai_pkg::req_type            req_data,
   output logic                        rsp_valid,
   output sai_pkg::rsp_type            rsp_data,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [sai_pkg::SETS_W-1:0]  csr_wdata
);
   import sai_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       csr_fire;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   sai_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .csr_fire (csr_fire),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   sai_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

### hw/rtl/sai_checker.sv
// Port-level checks for the set-associative id index, bound to the top level.
// Depends on sai_pkg.
module sai_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input sai_pkg::rsp_type rsp_data
);
   import sai_pkg::*;

   // Reset always starts a sweep of the tag memory.
   a_reset_busy: assert property (@(posedge clock) reset |=> busy)
      else $error("busy low after reset");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted beat did not raise busy");

   // Each item is taken only once the last one has gone through all its steps, so strobes never come back to back.
   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobes in consecutive cycles");

   a_found_loc: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.found) |-> !rsp_data.location[LOC_W-1])
      else $error("negative location on a found result");

   // A failed add keeps its id and reports the full-set marker.
   a_full_add: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.found && !rsp_data.return_id[RID_W-1])
         |-> (rsp_data.location == '1))
      else $error("failed add without full-set marker");

endmodule

bind set_assoc_id_index_core sai_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

### test/testbench.sv
// Self-checking testbench for set_assoc_id_index_core: it drives lookups and adds,
// predicts every response from a software copy of the tag store, and checks each one.
// Depends on sai_pkg and the core's RTL.
module testbench;
   import sai_pkg::*;

   // Keeps a copy of the tag store and the set count, and holds the responses
   // still owed by the core, oldest first.
   class id_slot_tracker;
      bit                slot_valid [NUM_SETS*WAYS];
      logic [ID_W-1:0]   slot_id [NUM_SETS*WAYS];
      int unsigned       occupancy;
      logic [SETS_W-1:0] sets_reg;
      rsp_type           due_results[$];
      int                errors;

      // A csr write changes the slot mapping, so the core empties the whole store.
      function void load_sets(logic [SETS_W-1:0] value);
         sets_reg = value;
         foreach (slot_valid[i]) slot_valid[i] = 1'b0;
         occupancy = 0;
      endfunction

      function int unsigned sets_used();
         if (sets_reg == 0) return 1;
         if (sets_reg > NUM_SETS) return NUM_SETS;
         return sets_reg;
      endfunction

      function void predict_item(req_type item);
         rsp_type     res;
         int unsigned sets;
         int unsigned base;
         int unsigned slot;
         int          w;
         sets = sets_used();
         base = (item.id % sets) * WAYS;
         res.found = 1'b0;
         res.last_out = item.batch_end;
         if (item.action == ACT_LOOKUP) begin
            res.location = LOC_W'(sets * WAYS);
            res.return_id = '1;
            for (w = 0; w < WAYS; w++) begin
               slot = base + w;
               if (slot_valid[slot] && slot_id[slot] == item.id) begin
                  res.location = LOC_W'(slot);
                  res.return_id = {1'b0, item.id};
                  res.found = 1'b1;
                  break;
               end
            end
         end else begin
            res.location = '1;
            res.return_id = {1'b0, item.id};
            for (w = 0; w < WAYS; w++) begin
               slot = base + w;
               if (!slot_valid[slot]) begin
                  slot_valid[slot] = 1'b1;
                  slot_id[slot] = item.id;
                  occupancy++;
                  res.location = LOC_W'(slot);
                  res.found = 1'b1;
                  break;
               end
            end
         end
         res.occupied = OCC_W'(occupancy);
         due_results.push_back(res);
      endfunction

      function void report_field(string field, longint want, longint got);
         errors++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (due_results.size() == 0) begin
            errors++;
            $display("%0t: response with nothing pending, got %p", $time, got);
            return;
         end
         want = due_results.pop_front();
         if (got.location !== want.location)
            report_field("location", want.location, got.location);
         if (got.found !== want.found)
            report_field("found", want.found, got.found);
         if (got.return_id !== want.return_id)
            report_field("return_id", want.return_id, got.return_id);
         if (got.occupied !== want.occupied)
            report_field("occupied", want.occupied, got.occupied);
         if (got.last_out !== want.last_out)
            report_field("last_out", want.last_out, got.last_out);
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset;
   logic              start;
   logic              busy;
   req_type           req_data;
   logic              rsp_valid;
   rsp_type           rsp_data;
   logic              csr_valid;
   logic              csr_ready;
   logic [SETS_W-1:0] csr_wdata;

   id_slot_tracker    board;
   logic [ID_W-1:0]   added_ids[$];

   // Set counts and sender idle rates, one pair per phase.
   int unsigned phase_sets [8] = '{1, 0, 2047, 3, 1024, 5, 1000, 2};
   int unsigned phase_idle [8] = '{0, 61, 26, 61, 0, 26, 61, 0};

   set_assoc_id_index_core dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) board.check_result(rsp_data);
   end

   function automatic req_type make_req(logic act, logic [ID_W-1:0] id, logic last);
      req_type r;
      r.action = act;
      r.id = id;
      r.batch_end = last;
      return r;
   endfunction

   // Almost half the ids come from recent adds, so lookups hit and sets fill up; some are
   // neighbors in the same set, the rest small or fully random values.
   function automatic logic [ID_W-1:0] pick_id();
      bit [31:0] raw;
      int unsigned sel;
      sel = $urandom_range(99);
      if (added_ids.size() != 0 && sel < 45) begin
         raw = {1'b0, added_ids[$urandom_range(added_ids.size() - 1)]};
      end else if (added_ids.size() != 0 && sel < 60) begin
         raw = added_ids[$urandom_range(added_ids.size() - 1)]
               + board.sets_used() * $urandom_range(1, 4);
      end else if (sel < 75) begin
         raw = $urandom_range(63);
      end else begin
         raw = $urandom;
      end
      return raw[ID_W-1:0];
   endfunction

   // Called at a falling edge; returns at a falling edge after the beat is taken.
   task automatic issue(input req_type item, input int unsigned idle_pct);
      while ($urandom_range(99) < idle_pct) @(negedge clock);
      start = 1'b1;
      req_data = item;
      do @(posedge clock); while (busy);
      board.predict_item(item);
      if (item.action == ACT_ADD) begin
         added_ids.push_back(item.id);
         if (added_ids.size() > 48) void'(added_ids.pop_front());
      end
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic write_sets(input logic [SETS_W-1:0] value);
      csr_valid = 1'b1;
      csr_wdata = value;
      do @(posedge clock); while (!csr_ready);
      board.load_sets(value);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic drain();
      while (board.due_results.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      req_type item;
      board = new();
      board.load_sets(SETS_W'(NUM_SETS));
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_wdata = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Empty store, lowest and highest ids, a set filled by duplicates and
      // then overflowed, and a miss and a failed add on another id of that full set.
      issue(make_req(ACT_LOOKUP, '0, 1'b0), 0);
      issue(make_req(ACT_ADD, '0, 1'b1), 0);
      issue(make_req(ACT_LOOKUP, '0, 1'b0), 0);
      issue(make_req(ACT_ADD, '1, 1'b0), 0);
      issue(make_req(ACT_LOOKUP, '1, 1'b1), 0);
      repeat (WAYS + 1) issue(make_req(ACT_ADD, ID_W'(5), 1'b0), 0);
      issue(make_req(ACT_LOOKUP, ID_W'(5), 1'b1), 0);
      issue(make_req(ACT_LOOKUP, ID_W'(5 + NUM_SETS), 1'b0), 0);
      issue(make_req(ACT_ADD, ID_W'(5 + NUM_SETS), 1'b1), 0);
      issue(make_req(ACT_ADD, 31'h2AAA_AAAA, 1'b1), 0);
      issue(make_req(ACT_ADD, 31'h5555_5555, 1'b0), 0);
      issue(make_req(ACT_LOOKUP, 31'h2AAA_AAAA, 1'b0), 0);
      issue(make_req(ACT_LOOKUP, 31'h5555_5555, 1'b1), 0);
      drain();

      for (int p = 0; p < 8; p++) begin
         write_sets(SETS_W'(phase_sets[p]));
         for (int n = 0; n < 110; n++) begin
            item.action = ($urandom_range(99) < 55) ? ACT_ADD : ACT_LOOKUP;
            item.id = pick_id();
            item.batch_end = 1'($urandom_range(1));
            issue(item, phase_idle[p]);
            // Now and then let the core run completely dry before going on.
            if (phase_idle[p] == 61 && n % 37 == 36) drain();
         end
         drain();
      end

      repeat (10) @(posedge clock);
      if (board.errors == 0 && board.due_results.size() == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

   initial begin
      #400000;
      $display("testbench: done, errors");
      $finish;
   end

endmodule

### set_assoc_id_index_core.f
hw/rtl/sai_pkg.sv
hw/rtl/sai_ram.sv
hw/rtl/sai_ctrl.sv
hw/rtl/sai_dp.sv
hw/rtl/set_assoc_id_index_core.sv
hw/rtl/sai_checker.sv
test/testbench.sv
